// File: hdl/cht_pkg.sv
// shared types and constants for the capability handle table
`default_nettype none

package cht_pkg;

	// default number of table slots, slot 0 reserved
	localparam int unsigned TABLE_SLOTS_DEF = 256;

	// saturation and exhaustion limit for counts and epochs
	localparam logic [15:0] FIELD_MAX = 16'hFFFF;

	// request codes
	typedef enum logic [2:0] {
		REQ_ALLOC  = 3'd0,
		REQ_LOOKUP = 3'd1,
		REQ_INC    = 3'd2,
		REQ_DEC    = 3'd3,
		REQ_REMOVE = 3'd4,
		REQ_REVOKE = 3'd5
	} req_type_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FAIL      = 2'd1,
		STAT_EXHAUSTED = 2'd2
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_EXEC
	} fsm_state_t;

	// one table entry as held in the entry memory
	typedef struct packed {
		logic [15:0] kind;
		logic [15:0] refs;
		logic [15:0] epoch;
		logic [31:0] resource;
		logic [31:0] rights;
		logic [31:0] owner;
	} slot_entry_t;

endpackage

`default_nettype wire

// File: hdl/capability_handle_table.sv
// capability handle table: generational ids over an entry memory and a lifo free list
// Timing: an accepted request is captured together with a registered read of the entry memory
// and the free-list head link, then executed in the exec state, which writes back and registers
// the result once no presented result is stalled. A new request is taken only after that.
// Reset: after arst_n the block sweeps the entry and free-list memories, one slot a cycle,
// for TABLE_SLOTS cycles, and accepts no request until the sweep is done.
`default_nettype none

module capability_handle_table
	import cht_pkg::*;
#(
	parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  req_type,
	input  wire logic [31:0] handle_id,
	input  wire logic [15:0] new_kind,
	input  wire logic [31:0] new_resource,
	input  wire logic [31:0] new_rights,
	input  wire logic [31:0] new_owner,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [31:0]      issued_id,
	output logic [15:0]      found_kind,
	output logic [15:0]      found_refs,
	output logic [15:0]      found_epoch,
	output logic [31:0]      found_resource,
	output logic [31:0]      found_rights,
	output logic [31:0]      found_owner
);

	localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

	// storage
	slot_entry_t      entry_mem [TABLE_SLOTS];
	logic [IDX_W-1:0] link_mem  [TABLE_SLOTS];

	fsm_state_t       state_q, state_d;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] free_top_q, free_top_d;
	logic [16:0]      cur_epoch_q, cur_epoch_d;

	// captured request
	logic [2:0]       req_q;
	logic [31:0]      hid_q;
	logic [15:0]      kind_q;
	logic [31:0]      res_q;
	logic [31:0]      rights_q;
	logic [31:0]      owner_q;

	// registered memory read data
	slot_entry_t      entry_rd_q;
	logic [IDX_W-1:0] link_rd_q;

	// result register
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [31:0]      issued_q;
	slot_entry_t      found_q;

	// combinational controls
	logic             accept;
	logic             exec_go;
	logic [IDX_W-1:0] rd_addr;
	logic             ent_we;
	logic [IDX_W-1:0] ent_waddr;
	slot_entry_t      ent_wdata;
	logic             lnk_we;
	logic [IDX_W-1:0] lnk_waddr;
	logic [IDX_W-1:0] lnk_wdata;
	status_t          stat_d;
	logic [31:0]      issued_d;
	slot_entry_t      found_d;

	logic [15:0]      hid_idx;
	logic [IDX_W-1:0] hid_addr;
	logic             hit;
	logic [15:0]      refs_dec;
	logic [15:0]      epoch_inc;

	assign hid_idx   = hid_q[15:0];
	assign hid_addr  = hid_q[IDX_W-1:0];
	assign refs_dec  = entry_rd_q.refs - 16'd1;
	assign epoch_inc = entry_rd_q.epoch + 16'd1;

	// id names a live entry with matching epoch
	assign hit = (hid_idx != 16'd0) && ({1'b0, hid_idx} < 17'(TABLE_SLOTS)) &&
		(entry_rd_q.kind != 16'd0) && (entry_rd_q.epoch == hid_q[31:16]);

	assign accept  = in_valid && in_ready;
	assign exec_go = (state_q == FSM_EXEC) && (!out_valid_q || out_ready);
	assign rd_addr = (req_type_t'(req_type) == REQ_ALLOC) ? free_top_q : handle_id[IDX_W-1:0];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory writes and request execution
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		ent_we      = 1'b0;
		ent_waddr   = clr_q;
		ent_wdata   = '0;
		lnk_we      = 1'b0;
		lnk_waddr   = clr_q;
		lnk_wdata   = (clr_q == LAST_IDX) ? '0 : IDX_W'(clr_q + 1'b1);
		free_top_d  = free_top_q;
		cur_epoch_d = cur_epoch_q;
		stat_d      = STAT_FAIL;
		issued_d    = 32'd0;
		found_d     = '0;
		case (state_q)
			FSM_CLEAR: begin
				ent_we = 1'b1;
				lnk_we = 1'b1;
				if (clr_q == LAST_IDX) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (exec_go) begin
					state_d = FSM_IDLE;
					ent_waddr = hid_addr;
					lnk_waddr = hid_addr;
					lnk_wdata = free_top_q;
					ent_wdata = '0;
					ent_wdata.epoch = entry_rd_q.epoch;
					case (req_type_t'(req_q))
						REQ_ALLOC: begin
							if (kind_q != 16'd0 && free_top_q != '0) begin
								ent_we              = 1'b1;
								ent_waddr           = free_top_q;
								ent_wdata.kind      = kind_q;
								ent_wdata.refs      = 16'd1;
								ent_wdata.epoch     = cur_epoch_q[15:0];
								ent_wdata.resource  = res_q;
								ent_wdata.rights    = rights_q;
								ent_wdata.owner     = owner_q;
								free_top_d          = link_rd_q;
								issued_d            = {cur_epoch_q[15:0], 16'(free_top_q)};
								stat_d              = STAT_OK;
							end
						end
						REQ_LOOKUP: begin
							if (hit) begin
								found_d = entry_rd_q;
								stat_d  = STAT_OK;
							end
						end
						REQ_INC: begin
							if (hit) begin
								ent_we    = 1'b1;
								ent_wdata = entry_rd_q;
								if (entry_rd_q.refs != FIELD_MAX) begin
									ent_wdata.refs = entry_rd_q.refs + 16'd1;
								end
								stat_d = STAT_OK;
							end
						end
						REQ_DEC: begin
							if (hit && entry_rd_q.refs != 16'd0) begin
								ent_we = 1'b1;
								stat_d = STAT_OK;
								if (refs_dec == 16'd0) begin
									// count reached zero: release the slot
									lnk_we     = 1'b1;
									free_top_d = hid_addr;
								end else begin
									ent_wdata      = entry_rd_q;
									ent_wdata.refs = refs_dec;
								end
							end
						end
						REQ_REMOVE: begin
							if (hit) begin
								ent_we     = 1'b1;
								lnk_we     = 1'b1;
								free_top_d = hid_addr;
								stat_d     = STAT_OK;
							end
						end
						REQ_REVOKE: begin
							if (hit) begin
								if (entry_rd_q.epoch == FIELD_MAX) begin
									stat_d = STAT_EXHAUSTED;
								end else begin
									ent_we          = 1'b1;
									ent_wdata.epoch = epoch_inc;
									lnk_we          = 1'b1;
									free_top_d      = hid_addr;
									if (cur_epoch_q <= {1'b0, epoch_inc}) begin
										cur_epoch_d = {1'b0, epoch_inc} + 17'd1;
									end
									stat_d = STAT_OK;
								end
							end
						end
						default: begin
							stat_d = STAT_FAIL;
						end
					endcase
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			free_top_q  <= IDX_W'(1);
			cur_epoch_q <= 17'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == FSM_CLEAR) begin
				clr_q <= IDX_W'(clr_q + 1'b1);
			end
			free_top_q  <= free_top_d;
			cur_epoch_q <= cur_epoch_d;
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture on transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req_type;
			hid_q    <= handle_id;
			kind_q   <= new_kind;
			res_q    <= new_resource;
			rights_q <= new_rights;
			owner_q  <= new_owner;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (exec_go) begin
			status_q <= stat_d;
			issued_q <= issued_d;
			found_q  <= found_d;
		end
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (ent_we) begin
			entry_mem[ent_waddr] <= ent_wdata;
		end
		if (accept) begin
			entry_rd_q <= entry_mem[rd_addr];
		end
	end

	// free-list link memory
	always_ff @(posedge clk) begin
		if (lnk_we) begin
			link_mem[lnk_waddr] <= lnk_wdata;
		end
		if (accept) begin
			link_rd_q <= link_mem[free_top_q];
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign issued_id      = issued_q;
	assign found_kind     = found_q.kind;
	assign found_refs     = found_q.refs;
	assign found_epoch    = found_q.epoch;
	assign found_resource = found_q.resource;
	assign found_rights   = found_q.rights;
	assign found_owner    = found_q.owner;

endmodule

`default_nettype wire

// File: hdl/cht_checker.sv
// port-level checks for the capability handle table, bound to the top level
`default_nettype none

module cht_checker
	import cht_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [31:0] issued_id,
	input wire logic [15:0] found_kind
);

	// a stalled result stays presented
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// failed requests carry no id and no entry
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> issued_id == 32'd0 && found_kind == 16'd0)
		else $error("failed request returned data");

	// an issued id never names the reserved slot and comes with no entry
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && issued_id != 32'd0 |-> issued_id[15:0] != 16'd0 && found_kind == 16'd0)
		else $error("issued id names reserved slot");

	// after a transaction is taken while no result is presented, the input is not ready in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !in_ready)
		else $error("input taken twice without execution");

endmodule

bind capability_handle_table cht_checker u_cht_checker (.*);

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the capability handle table: random and directed requests
module tb_top;
	import cht_pkg::*;

	localparam int unsigned SLOTS = TABLE_SLOTS_DEF;
	localparam logic [2:0] REQ_RESERVED_A = 3'd6;
	localparam logic [2:0] REQ_RESERVED_B = 3'd7;

	// one request as presented on the input channel
	typedef struct {
		logic [2:0]  op;
		logic [31:0] id;
		logic [15:0] kind;
		logic [31:0] resource;
		logic [31:0] rights;
		logic [31:0] owner;
	} table_req_t;

	// one result as expected on the output channel
	typedef struct {
		status_t     status;
		logic [31:0] issued_id;
		slot_entry_t entry;
	} table_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  req_type = '0;
	logic [31:0] handle_id = '0;
	logic [15:0] new_kind = '0;
	logic [31:0] new_resource = '0;
	logic [31:0] new_rights = '0;
	logic [31:0] new_owner = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [31:0] issued_id;
	logic [15:0] found_kind;
	logic [15:0] found_refs;
	logic [15:0] found_epoch;
	logic [31:0] found_resource;
	logic [31:0] found_rights;
	logic [31:0] found_owner;

	// shadow copy of the table
	slot_entry_t shadow_slot [SLOTS];
	int unsigned shadow_link [SLOTS];
	int unsigned shadow_head;
	logic [16:0] shadow_epoch;
	logic [31:0] last_issued = '0;

	// traffic bookkeeping
	table_req_t   pending_reqs [$];
	table_reply_t expected_replies [$];
	table_req_t   next_req;
	table_req_t   taken;
	table_reply_t want;
	int unsigned  n_queued = 0;
	int unsigned  n_accepted = 0;
	int unsigned  n_errors = 0;
	int unsigned  send_gap_max = 0;
	int unsigned  recv_gap_max = 0;
	int unsigned  send_wait = 0;
	int unsigned  recv_wait = 0;
	logic         in_fire = 1'b0;
	logic         out_fire = 1'b0;

	capability_handle_table dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.handle_id      (handle_id),
		.new_kind       (new_kind),
		.new_resource   (new_resource),
		.new_rights     (new_rights),
		.new_owner      (new_owner),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.issued_id      (issued_id),
		.found_kind     (found_kind),
		.found_refs     (found_refs),
		.found_epoch    (found_epoch),
		.found_resource (found_resource),
		.found_rights   (found_rights),
		.found_owner    (found_owner)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// slot index of a live entry whose epoch matches the id, else zero
	function automatic int unsigned resolve_handle(input logic [31:0] id);
		int unsigned idx;
		idx = id[15:0];
		if (idx == 0 || idx >= SLOTS)
			return 0;
		if (shadow_slot[idx].kind == '0 || shadow_slot[idx].epoch != id[31:16])
			return 0;
		return idx;
	endfunction

	// clear an entry but keep its epoch, push it on the free list
	function automatic void free_slot(input int unsigned idx);
		shadow_slot[idx].kind = '0;
		shadow_slot[idx].refs = '0;
		shadow_slot[idx].resource = '0;
		shadow_slot[idx].rights = '0;
		shadow_slot[idx].owner = '0;
		shadow_link[idx] = shadow_head;
		shadow_head = idx;
	endfunction

	// apply one request to the shadow table and return its result
	function automatic table_reply_t apply_request(input table_req_t r);
		table_reply_t rep;
		int unsigned idx;
		rep.status = STAT_FAIL;
		rep.issued_id = '0;
		rep.entry = '0;
		idx = resolve_handle(r.id);
		case (r.op)
			REQ_ALLOC: begin
				idx = shadow_head;
				if (r.kind != '0 && idx != 0 && idx < SLOTS) begin
					shadow_head = shadow_link[idx];
					shadow_slot[idx] = '{kind: r.kind, refs: 16'd1, epoch: shadow_epoch[15:0],
						resource: r.resource, rights: r.rights, owner: r.owner};
					rep.issued_id = {shadow_epoch[15:0], 16'(idx)};
					last_issued = rep.issued_id;
					rep.status = STAT_OK;
				end
			end
			REQ_LOOKUP: begin
				if (idx != 0) begin
					rep.entry = shadow_slot[idx];
					rep.status = STAT_OK;
				end
			end
			REQ_INC: begin
				if (idx != 0) begin
					if (shadow_slot[idx].refs != FIELD_MAX)
						shadow_slot[idx].refs = shadow_slot[idx].refs + 16'd1;
					rep.status = STAT_OK;
				end
			end
			REQ_DEC: begin
				if (idx != 0 && shadow_slot[idx].refs != '0) begin
					shadow_slot[idx].refs = shadow_slot[idx].refs - 16'd1;
					if (shadow_slot[idx].refs == '0)
						free_slot(idx);
					rep.status = STAT_OK;
				end
			end
			REQ_REMOVE: begin
				if (idx != 0) begin
					free_slot(idx);
					rep.status = STAT_OK;
				end
			end
			REQ_REVOKE: begin
				if (idx != 0) begin
					if (shadow_slot[idx].epoch == FIELD_MAX) begin
						rep.status = STAT_EXHAUSTED;
					end else begin
						shadow_slot[idx].epoch = shadow_slot[idx].epoch + 16'd1;
						if (shadow_epoch <= {1'b0, shadow_slot[idx].epoch})
							shadow_epoch = {1'b0, shadow_slot[idx].epoch} + 17'd1;
						free_slot(idx);
						rep.status = STAT_OK;
					end
				end
			end
			default: begin
			end
		endcase
		return rep;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			n_errors++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
				$time, name, exp_val, act_val);
		end
	endtask

	// handshake sampling, result checking and prediction of accepted requests
	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		out_fire <= out_valid && out_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					n_errors++;
					$display("%0t ns: result with none expected, expected nothing, actual status %0h",
						$time, status);
				end else begin
					want = expected_replies.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("issued_id", want.issued_id, issued_id);
					check_field("found_kind", 32'(want.entry.kind), 32'(found_kind));
					check_field("found_refs", 32'(want.entry.refs), 32'(found_refs));
					check_field("found_epoch", 32'(want.entry.epoch), 32'(found_epoch));
					check_field("found_resource", want.entry.resource, found_resource);
					check_field("found_rights", want.entry.rights, found_rights);
					check_field("found_owner", want.entry.owner, found_owner);
				end
			end
			if (in_valid && in_ready) begin
				taken = '{op: req_type, id: handle_id, kind: new_kind, resource: new_resource,
					rights: new_rights, owner: new_owner};
				expected_replies.push_back(apply_request(taken));
				n_accepted++;
			end
		end
	end

	// request driver: holds each transaction until taken, then waits its drawn gap
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (send_wait > 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				next_req = pending_reqs.pop_front();
				req_type <= next_req.op;
				handle_id <= next_req.id;
				new_kind <= next_req.kind;
				new_resource <= next_req.resource;
				new_rights <= next_req.rights;
				new_owner <= next_req.owner;
				in_valid <= 1'b1;
				send_wait = $urandom_range(0, send_gap_max);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result acceptor: stalls each result for a drawn number of cycles
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire)
				recv_wait = $urandom_range(0, recv_gap_max);
			else if (recv_wait > 0 && out_valid)
				recv_wait--;
			out_ready <= (recv_wait == 0);
		end
	end

	// queue one transaction and wait until the block has taken it
	task automatic send_req(input logic [2:0] req_op, input logic [31:0] req_id,
			input logic [15:0] req_kind, input logic [31:0] req_resource,
			input logic [31:0] req_rights, input logic [31:0] req_owner);
		table_req_t r;
		r = '{op: req_op, id: req_id, kind: req_kind, resource: req_resource,
			rights: req_rights, owner: req_owner};
		pending_reqs.push_back(r);
		n_queued++;
		wait (n_accepted == n_queued);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// request on an id with random alloc fields
	task automatic send_on(input logic [2:0] req_op, input logic [31:0] req_id);
		send_req(req_op, req_id, 16'($urandom), rand_word(), rand_word(), rand_word());
	endtask

	// mostly live ids, otherwise random, reserved, out of range, stale or free ones
	function automatic logic [31:0] pick_target_id();
		int unsigned live [$];
		int unsigned idx;
		int unsigned i;
		for (i = 1; i < SLOTS; i++)
			if (shadow_slot[i].kind != '0)
				live.push_back(i);
		if (live.size() != 0 && $urandom_range(0, 9) < 8) begin
			idx = live[$urandom_range(0, live.size() - 1)];
			return {shadow_slot[idx].epoch, 16'(idx)};
		end
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return {16'($urandom), 16'h0000};
			2: return {16'($urandom), 16'($urandom_range(SLOTS, 16'hFFFF))};
			3: begin
				idx = $urandom_range(1, SLOTS - 1);
				return {shadow_slot[idx].epoch + 16'd1, 16'(idx)};
			end
			default: begin
				idx = $urandom_range(1, SLOTS - 1);
				return {shadow_slot[idx].epoch, 16'(idx)};
			end
		endcase
	endfunction

	// one random request, alloc_pct sets the share of allocations
	task automatic random_request(input int unsigned alloc_pct);
		logic [2:0] op;
		logic [15:0] kind;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			op = ($urandom_range(0, 1) == 0) ? REQ_RESERVED_A : REQ_RESERVED_B;
		end else if (pick < 4 + alloc_pct) begin
			op = REQ_ALLOC;
		end else begin
			case ($urandom_range(0, 4))
				0: op = REQ_LOOKUP;
				1: op = REQ_INC;
				2: op = REQ_DEC;
				3: op = REQ_REMOVE;
				default: op = REQ_REVOKE;
			endcase
		end
		kind = ($urandom_range(0, 19) == 0) ? 16'h0000 : 16'($urandom);
		send_req(op, pick_target_id(), kind, rand_word(), rand_word(), rand_word());
	endtask

	// timeout
	initial begin
		#12_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// stimulus sequence
	initial begin
		int unsigned i;
		logic [31:0] held;
		logic [31:0] other;

		// shadow state after reset
		for (i = 0; i < SLOTS; i++) begin
			shadow_slot[i] = '0;
			shadow_link[i] = (i + 1 < SLOTS) ? i + 1 : 0;
		end
		shadow_head = 1;
		shadow_epoch = 17'd1;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, bad ids, free and stale entries, unknown requests
		send_gap_max = 2;
		recv_gap_max = 2;
		send_on(REQ_LOOKUP, 32'h0001_0000);
		send_req(REQ_ALLOC, '0, 16'h0000, '1, '1, '1);
		send_req(REQ_ALLOC, '1, 16'hFFFF, '1, '1, '1);
		held = last_issued;
		send_on(REQ_LOOKUP, held);
		send_req(REQ_ALLOC, '0, 16'h0001, '0, '0, '0);
		other = last_issued;
		send_on(REQ_LOOKUP, {held[31:16] + 16'd1, held[15:0]});
		send_on(REQ_LOOKUP, {held[31:16], 16'(SLOTS)});
		send_on(REQ_LOOKUP, '1);
		send_on(REQ_INC, held);
		send_on(REQ_LOOKUP, held);
		send_on(REQ_DEC, held);
		send_on(REQ_DEC, held);
		send_on(REQ_LOOKUP, held);
		send_on(REQ_INC, held);
		send_on(REQ_REVOKE, other);
		send_on(REQ_LOOKUP, other);
		send_req(REQ_ALLOC, '0, 16'h8000, $urandom, $urandom, $urandom);
		held = last_issued;
		send_on(REQ_REMOVE, held);
		send_on(REQ_REMOVE, held);
		send_on(REQ_RESERVED_A, held);
		send_on(REQ_RESERVED_B, '1);
		send_on(REQ_LOOKUP, {16'h0001, 16'd3});

		// mixed random traffic
		send_gap_max = 6;
		recv_gap_max = 6;
		repeat (200) random_request(35);

		// fill the table until allocation fails, then drain it
		while (shadow_head != 0)
			random_request(90);
		repeat (20) random_request(90);
		repeat (250) random_request(10);

		// back-to-back stretch
		send_gap_max = 0;
		recv_gap_max = 0;
		repeat (100) random_request(35);

		// random tail
		send_gap_max = 6;
		recv_gap_max = 6;
		repeat (60) random_request(35);

		// drain outstanding results
		wait (expected_replies.size() == 0);
		repeat (20) @(posedge clk);
		if (n_errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
hdl/cht_pkg.sv
hdl/capability_handle_table.sv
hdl/cht_checker.sv
verif/tb_top.sv
